### sv/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int CURSOR_STRIDE = 80;
    localparam int TAB_STEP      = 3;
    localparam int ALU_W         = 14;
    localparam int POS_W         = 11;
    localparam int CFG_W         = 4;

    typedef logic [ALU_W-1:0] t_alu_word;
    typedef logic [CFG_W-1:0] t_color;
    typedef logic [0:0]       t_cfg_index;

    localparam t_cfg_index CFG_FG = 1'b0;
    localparam t_cfg_index CFG_BG = 1'b1;

    localparam t_color FG_RESET = 4'd7;
    localparam t_color BG_RESET = 4'd0;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] cursor_position;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
    } t_out_item;

    typedef struct packed {
        t_alu_word a;
        t_alu_word b;
        logic      sub;
        t_alu_word lim;
    } t_alu_req;

    typedef struct packed {
        t_alu_word res;
        logic      ge;
    } t_alu_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FOLD,
        S_ROWCHK,
        S_SCR_RD,
        S_SCR_WR,
        S_FILL,
        S_CHAR,
        S_ADV,
        S_READ,
        S_RDATA,
        S_PUSH
    } t_state;

endpackage

### sv/tcw_alu.sv
`timescale 1ns / 1ps

module tcw_alu (
    input  tcw_pkg::t_alu_req i_req,
    output tcw_pkg::t_alu_rsp o_rsp
);

    always_comb begin
        o_rsp.res = i_req.sub ? (i_req.a - i_req.b) : (i_req.a + i_req.b);
        o_rsp.ge  = (i_req.a >= i_req.lim);
    end

endmodule

### sv/text_console_character_writer_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        sink       i_in_valid/o_in_stall  i_in_data  (op, char_code, cell_index)
// out       source     o_out_valid/i_out_stall o_out_data (cursor_position, cell_char, cell_attr)
// cfg       sink       i_cfg_we               i_cfg_index, i_cfg_wdata
//
// One transaction at a time through a single shared add/subtract/compare unit.
// Scroll moves characters up a row, one read and one write per moved cell.
// Clear fills every cell, one cell written per cycle.
// Synchronous active-low reset; cell memory has no clearing pass after reset.
// A stalled result holds in the output register while the next transaction is taken.

module text_console_character_writer_core #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tcw_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tcw_pkg::t_out_item   o_out_data,
    input  logic                 i_cfg_we,
    input  tcw_pkg::t_cfg_index  i_cfg_index,
    input  tcw_pkg::t_color      i_cfg_wdata
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS + 3);
    localparam int ROW_W  = $clog2(ROWS + 1);

    tcw_pkg::t_state    r_state, n_state;
    logic [7:0]         r_ch, n_ch;
    logic [10:0]        r_cell, n_cell;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic               r_fill_all, n_fill_all;
    logic               r_oor, n_oor;
    logic [7:0]         r_rc, n_rc;
    logic [7:0]         r_ra, n_ra;
    tcw_pkg::t_color    r_fg, r_bg;
    logic               r_out_valid, n_out_valid;
    tcw_pkg::t_out_item r_out_data, n_out_data;

    logic [7:0]         r_char_mem [CELLS];
    logic [7:0]         r_attr_mem [CELLS];
    logic [7:0]         r_char_q;
    logic [7:0]         r_attr_q;

    tcw_pkg::t_alu_req  alu_req;
    tcw_pkg::t_alu_rsp  alu_rsp;
    tcw_pkg::t_alu_word cell_ext;
    tcw_pkg::t_alu_word row_base;
    tcw_pkg::t_alu_word pos_base;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ADDR_W-1:0]  mem_waddr;
    logic               char_we;
    logic               attr_we;
    logic [7:0]         char_wdata;
    logic               in_accept;
    logic               out_free;
    logic               is_printable;

    tcw_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign o_in_stall  = (r_state != tcw_pkg::S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign cell_ext = tcw_pkg::t_alu_word'(r_cell);
    assign row_base = tcw_pkg::t_alu_word'(r_row) * tcw_pkg::t_alu_word'(COLUMNS);
    assign pos_base = tcw_pkg::t_alu_word'(r_row)
                      * tcw_pkg::t_alu_word'(tcw_pkg::CURSOR_STRIDE);

    assign is_printable = (r_ch != tcw_pkg::CH_NL) && (r_ch != tcw_pkg::CH_CR)
                          && (r_ch != tcw_pkg::CH_TAB) && (r_ch != tcw_pkg::CH_BS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::S_IDLE: begin
                if (in_accept) begin
                    case (i_in_data.op)
                        tcw_pkg::OP_PUT:   n_state = tcw_pkg::S_FOLD;
                        tcw_pkg::OP_CLEAR: n_state = tcw_pkg::S_FILL;
                        tcw_pkg::OP_READ:  n_state = tcw_pkg::S_READ;
                        default:           n_state = tcw_pkg::S_PUSH;
                    endcase
                end
            end
            tcw_pkg::S_FOLD:   n_state = tcw_pkg::S_ROWCHK;
            tcw_pkg::S_ROWCHK: n_state = alu_rsp.ge ? tcw_pkg::S_SCR_RD : tcw_pkg::S_CHAR;
            tcw_pkg::S_SCR_RD: n_state = tcw_pkg::S_SCR_WR;
            tcw_pkg::S_SCR_WR: n_state = alu_rsp.ge ? tcw_pkg::S_FILL : tcw_pkg::S_SCR_RD;
            tcw_pkg::S_FILL: begin
                if (alu_rsp.ge) begin
                    n_state = r_fill_all ? tcw_pkg::S_PUSH : tcw_pkg::S_CHAR;
                end
            end
            tcw_pkg::S_CHAR:   n_state = is_printable ? tcw_pkg::S_ADV : tcw_pkg::S_PUSH;
            tcw_pkg::S_ADV:    n_state = tcw_pkg::S_PUSH;
            tcw_pkg::S_READ:   n_state = tcw_pkg::S_RDATA;
            tcw_pkg::S_RDATA:  n_state = tcw_pkg::S_PUSH;
            tcw_pkg::S_PUSH: begin
                if (out_free) begin
                    n_state = tcw_pkg::S_IDLE;
                end
            end
            default:           n_state = tcw_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_ch        = r_ch;
        n_cell      = r_cell;
        n_row       = r_row;
        n_col       = r_col;
        n_addr      = r_addr;
        n_fill_all  = r_fill_all;
        n_oor       = r_oor;
        n_rc        = r_rc;
        n_ra        = r_ra;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        alu_req     = '0;
        mem_raddr   = cell_ext[ADDR_W-1:0];
        mem_waddr   = r_addr;
        char_we     = 1'b0;
        attr_we     = 1'b0;
        char_wdata  = tcw_pkg::CH_SPACE;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            tcw_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_ch   = i_in_data.char_code;
                    n_cell = i_in_data.cell_index;
                    n_rc   = '0;
                    n_ra   = '0;
                    if (i_in_data.op == tcw_pkg::OP_CLEAR) begin
                        n_addr     = '0;
                        n_fill_all = 1'b1;
                        n_row      = '0;
                        n_col      = '0;
                    end
                end
            end
            tcw_pkg::S_FOLD: begin
                alu_req.a   = tcw_pkg::t_alu_word'(r_col);
                alu_req.b   = tcw_pkg::t_alu_word'(COLUMNS);
                alu_req.sub = 1'b1;
                alu_req.lim = tcw_pkg::t_alu_word'(COLUMNS);
                if (alu_rsp.ge) begin
                    n_col = alu_rsp.res[COL_W-1:0];
                    n_row = ROW_W'(r_row + 1'b1);
                end
            end
            tcw_pkg::S_ROWCHK: begin
                alu_req.a   = tcw_pkg::t_alu_word'(r_row);
                alu_req.lim = tcw_pkg::t_alu_word'(ROWS);
                if (alu_rsp.ge) begin
                    n_row      = ROW_W'(ROWS - 1);
                    n_addr     = '0;
                    n_fill_all = 1'b0;
                end
            end
            tcw_pkg::S_SCR_RD: begin
                alu_req.a = tcw_pkg::t_alu_word'(r_addr);
                alu_req.b = tcw_pkg::t_alu_word'(COLUMNS);
                mem_raddr = alu_rsp.res[ADDR_W-1:0];
            end
            tcw_pkg::S_SCR_WR: begin
                alu_req.a   = tcw_pkg::t_alu_word'(r_addr);
                alu_req.b   = tcw_pkg::t_alu_word'(1);
                alu_req.lim = tcw_pkg::t_alu_word'(CELLS - COLUMNS - 1);
                char_we     = 1'b1;
                char_wdata  = r_char_q;
                n_addr      = alu_rsp.res[ADDR_W-1:0];
            end
            tcw_pkg::S_FILL: begin
                alu_req.a   = tcw_pkg::t_alu_word'(r_addr);
                alu_req.b   = tcw_pkg::t_alu_word'(1);
                alu_req.lim = tcw_pkg::t_alu_word'(CELLS - 1);
                char_we     = 1'b1;
                attr_we     = r_fill_all;
                n_addr      = alu_rsp.res[ADDR_W-1:0];
            end
            tcw_pkg::S_CHAR: begin
                case (r_ch) inside
                    tcw_pkg::CH_NL: begin
                        n_row = ROW_W'(r_row + 1'b1);
                        n_col = '0;
                    end
                    tcw_pkg::CH_CR: begin
                        n_col = '0;
                    end
                    tcw_pkg::CH_TAB: begin
                        alu_req.a = tcw_pkg::t_alu_word'(r_col);
                        alu_req.b = tcw_pkg::t_alu_word'(tcw_pkg::TAB_STEP);
                        n_col     = alu_rsp.res[COL_W-1:0];
                    end
                    tcw_pkg::CH_BS: begin
                        alu_req.a   = tcw_pkg::t_alu_word'(r_col);
                        alu_req.b   = tcw_pkg::t_alu_word'(1);
                        alu_req.sub = 1'b1;
                        alu_req.lim = tcw_pkg::t_alu_word'(1);
                        if (alu_rsp.ge) begin
                            n_col = alu_rsp.res[COL_W-1:0];
                        end
                    end
                    default: begin
                        alu_req.a  = row_base;
                        alu_req.b  = tcw_pkg::t_alu_word'(r_col);
                        mem_waddr  = alu_rsp.res[ADDR_W-1:0];
                        char_we    = 1'b1;
                        attr_we    = 1'b1;
                        char_wdata = r_ch;
                    end
                endcase
            end
            tcw_pkg::S_ADV: begin
                alu_req.a = tcw_pkg::t_alu_word'(r_col);
                alu_req.b = tcw_pkg::t_alu_word'(1);
                n_col     = alu_rsp.res[COL_W-1:0];
            end
            tcw_pkg::S_READ: begin
                alu_req.a   = cell_ext;
                alu_req.lim = tcw_pkg::t_alu_word'(CELLS);
                n_oor       = alu_rsp.ge;
            end
            tcw_pkg::S_RDATA: begin
                n_rc = r_oor ? 8'd0 : r_char_q;
                n_ra = r_oor ? 8'd0 : r_attr_q;
            end
            tcw_pkg::S_PUSH: begin
                alu_req.a = pos_base;
                alu_req.b = tcw_pkg::t_alu_word'(r_col);
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_data.cursor_position = alu_rsp.res[tcw_pkg::POS_W-1:0];
                    n_out_data.cell_char       = r_rc;
                    n_out_data.cell_attr       = r_ra;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_fill_all  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_fill_all  <= n_fill_all;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch       <= n_ch;
        r_cell     <= n_cell;
        r_addr     <= n_addr;
        r_oor      <= n_oor;
        r_rc       <= n_rc;
        r_ra       <= n_ra;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= tcw_pkg::FG_RESET;
            r_bg <= tcw_pkg::BG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcw_pkg::CFG_FG: r_fg <= i_cfg_wdata;
                tcw_pkg::CFG_BG: r_bg <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (char_we) begin
            r_char_mem[mem_waddr] <= char_wdata;
        end
        r_char_q <= r_char_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (attr_we) begin
            r_attr_mem[mem_waddr] <= {r_bg, r_fg};
        end
        r_attr_q <= r_attr_mem[mem_raddr];
    end

endmodule
